// File: design/tpdf_dither_24_to_16_macros.svh
// Assertion macros shared by the dither block.
// Each macro checks on the rising clock edge and is quiet while reset is held.
`ifndef TPDF_DITHER_24_TO_16_MACROS_SVH
`define TPDF_DITHER_24_TO_16_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds.
`define TPD_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Check that a condition never occurs.
`define TPD_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`else

`define TPD_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define TPD_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg)

`endif

`endif

// File: design/tpd_pkg.sv
`default_nettype none

package tpd_pkg;

    // Number of lanes carried by one word
    localparam int LANES = 4;

    localparam int IN_W   = 24;
    localparam int OUT_W  = 16;
    localparam int RNG_W  = 32;
    // Sample plus two 8-bit dither terms
    localparam int SUM_W  = IN_W + 2;
    // Quotient after the arithmetic shift right by 8
    localparam int Q_W    = SUM_W - 8;

    localparam logic [OUT_W-1:0] SAT_MAX = 16'h7FFF;
    localparam logic [OUT_W-1:0] SAT_MIN = 16'h8000;

    typedef logic signed [IN_W-1:0]  sample_t;
    typedef logic signed [OUT_W-1:0] pcm16_t;
    typedef logic [RNG_W-1:0]        rng_t;

    // Control from the output stage to every lane
    typedef struct packed {
        logic advance;
    } lane_ctl_t;

    // Reset seed of a lane: the four seeds repeat across lanes
    function automatic rng_t lane_seed(input int idx);
        logic [1:0] sel;
        rng_t       seed;
        sel = idx[1:0];
        case (sel)
            2'd0:    seed = 32'h12345678;
            2'd1:    seed = 32'h87654321;
            2'd2:    seed = 32'habcdef01;
            2'd3:    seed = 32'h10fedcba;
            default: seed = 32'h12345678;
        endcase
        return seed;
    endfunction

    // One xorshift32 step: left 13, right 17, left 5
    function automatic rng_t xs_next(input rng_t x);
        rng_t t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

`default_nettype wire

// File: design/tpd_lane.sv
`default_nettype none

`include "tpdf_dither_24_to_16_macros.svh"

module tpd_lane (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tpd_pkg::rng_t     seed,
    input  wire tpd_pkg::lane_ctl_t ctl,
    input  wire tpd_pkg::sample_t  sample,
    output tpd_pkg::pcm16_t        pcm
);

    tpd_pkg::rng_t rng_reg;
    tpd_pkg::rng_t rng_next;
    tpd_pkg::rng_t r1;
    tpd_pkg::rng_t r2;

    logic signed [tpd_pkg::SUM_W-1:0] sum;
    logic signed [tpd_pkg::Q_W-1:0]   quot;

    // Advance the generator twice per word
    always_comb
    begin
        r1       = tpd_pkg::xs_next(rng_reg);
        r2       = tpd_pkg::xs_next(r1);
        rng_next = ctl.advance ? r2 : rng_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg <= seed;
        end
        else
        begin
            rng_reg <= rng_next;
        end
    end

    // Add triangular dither, floor-shift by 8, clamp to 16 bits
    always_comb
    begin
        sum  = {{2{sample[tpd_pkg::IN_W-1]}}, sample}
             + {{(tpd_pkg::SUM_W-8){r1[7]}}, r1[7:0]}
             + {{(tpd_pkg::SUM_W-8){r2[7]}}, r2[7:0]};
        quot = sum[tpd_pkg::SUM_W-1:8];
        if ((quot[tpd_pkg::Q_W-1:tpd_pkg::OUT_W-1] == '0)
            || (quot[tpd_pkg::Q_W-1:tpd_pkg::OUT_W-1] == '1))
        begin
            pcm = quot[tpd_pkg::OUT_W-1:0];
        end
        else if (quot[tpd_pkg::Q_W-1])
        begin
            pcm = tpd_pkg::SAT_MIN;
        end
        else
        begin
            pcm = tpd_pkg::SAT_MAX;
        end
    end

    // A nonzero xorshift state never reaches zero
    `TPD_ASSERT_NEVER(a_rng_nonzero, clk, rst_n, rng_reg == '0, "lane generator state hit zero")
    // Every advance moves the state
    `TPD_ASSERT(a_rng_moves, clk, rst_n, ctl.advance |=> rng_reg != $past(rng_reg), "no advance")

endmodule

`default_nettype wire

// File: design/tpd_out_stage.sv
`default_nettype none

`include "tpdf_dither_24_to_16_macros.svh"

module tpd_out_stage (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 sample_valid,
    output logic                                      sample_stall,
    input  wire logic                                 end_of_block,
    input  wire logic [tpd_pkg::LANES-1:0][tpd_pkg::OUT_W-1:0] lane_pcm,
    output tpd_pkg::lane_ctl_t                        ctl,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic [tpd_pkg::LANES-1:0][tpd_pkg::OUT_W-1:0] result_pcm,
    output logic                                      last_out
);

    logic valid_reg;
    logic valid_next;
    logic last_reg;
    logic take;
    logic [tpd_pkg::LANES-1:0][tpd_pkg::OUT_W-1:0] pcm_reg;

    // Take a new word whenever the output register is empty or draining
    always_comb
    begin
        sample_stall = valid_reg && result_stall;
        take         = sample_valid && !sample_stall;
        ctl.advance  = take;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Merge the lane results into one output word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pcm_reg  <= lane_pcm;
            last_reg <= end_of_block;
        end
    end

    assign result_valid = valid_reg;
    assign result_pcm   = pcm_reg;
    assign last_out     = last_reg;

    // Never overwrite a word that waits on a stalled receiver
    `TPD_ASSERT_NEVER(a_no_overwrite, clk, rst_n, take && valid_reg && result_stall, "word lost")
    // A taken word shows up in the next cycle
    `TPD_ASSERT(a_take_shows, clk, rst_n, take |=> result_valid, "taken word not presented")

endmodule

`default_nettype wire

// File: design/tpdf_dither_24_to_16.sv
// TPDF dither, 24-bit to 16-bit, four lanes per word.
// Input channel: sample_lane0..3 and end_of_block, with sample_valid and
// sample_stall; a word is taken at a clock edge with valid high and stall low.
// Output channel: out_lane0..3 and last_out, with result_valid and
// result_stall driven by the receiver.
// Each lane runs its own xorshift32 generator, stepped twice per word; the low
// bytes of both values form the dither added before the shift and clamp.
// A taken word's result appears on the output register in the next cycle.
// Throughput: one word per cycle unless the receiver stalls; generators and
// adder are combinational; the output register takes a word while one drains.
// When the receiver stalls with a result held, sample_stall rises in the same
// cycle and the held result and all generator states stay put.
// Reset (rst_n low, asynchronous) empties the output register and loads the
// generator seeds; generators are never reseeded at the end of a block.
`default_nettype none

module tpdf_dither_24_to_16 (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic signed [23:0] sample_lane0,
    input  wire logic signed [23:0] sample_lane1,
    input  wire logic signed [23:0] sample_lane2,
    input  wire logic signed [23:0] sample_lane3,
    input  wire logic               end_of_block,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [15:0]      out_lane0,
    output logic signed [15:0]      out_lane1,
    output logic signed [15:0]      out_lane2,
    output logic signed [15:0]      out_lane3,
    output logic                    last_out
);

    tpd_pkg::sample_t   samples  [tpd_pkg::LANES];
    tpd_pkg::lane_ctl_t ctl;
    logic [tpd_pkg::LANES-1:0][tpd_pkg::OUT_W-1:0] lane_pcm;
    logic [tpd_pkg::LANES-1:0][tpd_pkg::OUT_W-1:0] result_pcm;

    // Spread the word over the lanes
    assign samples[0] = sample_lane0;
    assign samples[1] = sample_lane1;
    assign samples[2] = sample_lane2;
    assign samples[3] = sample_lane3;

    for (genvar i = 0; i < tpd_pkg::LANES; i++)
    begin : g_lane
        tpd_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .seed   (tpd_pkg::lane_seed(i)),
            .ctl    (ctl),
            .sample (samples[i]),
            .pcm    (lane_pcm[i])
        );
    end

    tpd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .end_of_block (end_of_block),
        .lane_pcm     (lane_pcm),
        .ctl          (ctl),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_pcm   (result_pcm),
        .last_out     (last_out)
    );

    assign out_lane0 = result_pcm[0];
    assign out_lane1 = result_pcm[1];
    assign out_lane2 = result_pcm[2];
    assign out_lane3 = result_pcm[3];

endmodule

`default_nettype wire

// File: bench/tpdf_dither_24_to_16_test.sv
`default_nettype none

module tpdf_dither_24_to_16_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tpd_pkg::*;

    localparam int RANDOM_WORDS   = 1440;
    localparam int CALM_WORDS     = 200;
    localparam int LONG_HOLD      = 60;
    localparam int RUSH_WORDS     = 40;
    localparam int HOLD_AT        = 300;
    localparam int PAUSE_AT       = 700;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam sample_t FULL_POS = 24'sh7FFFFF;
    localparam sample_t FULL_NEG = 24'sh800000;

    // Generator seeds, repeating every four lanes
    localparam rng_t LANE_SEEDS [4] = '{32'h12345678, 32'h87654321,
                                        32'habcdef01, 32'h10fedcba};

    // Tracks the per-lane dither generators and the words still owed
    class dither_tracker;
        typedef struct packed {
            logic                          last;
            logic [LANES-1:0][OUT_W-1:0]   pcm;
        } group_t;

        rng_t   lane_state [LANES];
        group_t owed_words [$];
        int     errors;
        int     words_checked;
        int     clamp_hits;
        int     block_ends;

        function new();
            foreach (lane_state[i])
                lane_state[i] = LANE_SEEDS[i % 4];
            errors        = 0;
            words_checked = 0;
            clamp_hits    = 0;
            block_ends    = 0;
        endfunction

        function rng_t xorshift_step(input rng_t x);
            rng_t t;
            t = x ^ (x << 13);
            t = t ^ (t >> 17);
            t = t ^ (t << 5);
            return t;
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        // Advance every lane twice and queue the requantized word
        function void note_group(input logic [LANES-1:0][IN_W-1:0] samples,
                                 input logic eob);
            group_t                 g;
            rng_t                   r1;
            rng_t                   r2;
            sample_t                smp;
            logic signed [7:0]      d1;
            logic signed [7:0]      d2;
            int                     acc;
            int                     q;
            for (int i = 0; i < LANES; i++)
            begin
                r1 = xorshift_step(lane_state[i]);
                r2 = xorshift_step(r1);
                lane_state[i] = r2;
                smp = samples[i];
                d1  = r1[7:0];
                d2  = r2[7:0];
                acc = smp + d1 + d2;
                q   = acc >>> 8;
                if (q > 32767)
                begin
                    q = 32767;
                    clamp_hits++;
                end
                else if (q < -32768)
                begin
                    q = -32768;
                    clamp_hits++;
                end
                g.pcm[i] = q[15:0];
            end
            g.last = eob;
            if (eob)
                block_ends++;
            owed_words.push_back(g);
        endfunction

        // Compare one output word with the oldest owed word
        function void check_group(input logic [LANES-1:0][OUT_W-1:0] pcm,
                                  input logic last);
            group_t g;
            if (owed_words.size() == 0)
            begin
                $display("%0t: output word with nothing owed, lane0 %0d last %0b",
                         $time, $signed(pcm[0]), last);
                errors++;
                return;
            end
            g = owed_words.pop_front();
            words_checked++;
            for (int i = 0; i < LANES; i++)
            begin
                if (pcm[i] !== g.pcm[i])
                begin
                    $display("%0t: lane %0d expected %0d, got %0d", $time, i,
                             $signed(g.pcm[i]), $signed(pcm[i]));
                    errors++;
                end
            end
            if (last !== g.last)
            begin
                $display("%0t: last_out expected %0b, got %0b", $time, g.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               sample_valid;
    logic               sample_stall;
    sample_t            sample_lane0;
    sample_t            sample_lane1;
    sample_t            sample_lane2;
    sample_t            sample_lane3;
    logic               end_of_block;
    logic               result_valid;
    logic               result_stall;
    pcm16_t             out_lane0;
    pcm16_t             out_lane1;
    pcm16_t             out_lane2;
    pcm16_t             out_lane3;
    logic               last_out;

    dither_tracker      sb;
    bit                 calm;
    bit                 long_hold_req;
    int                 rush_left;
    int                 idle_cycles;

    tpdf_dither_24_to_16 uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_lane0 (sample_lane0),
        .sample_lane1 (sample_lane1),
        .sample_lane2 (sample_lane2),
        .sample_lane3 (sample_lane3),
        .end_of_block (end_of_block),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_lane0    (out_lane0),
        .out_lane1    (out_lane1),
        .out_lane2    (out_lane2),
        .out_lane3    (out_lane3),
        .last_out     (last_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watch both channels at each edge: check outputs, then note inputs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_group({out_lane3, out_lane2, out_lane1, out_lane0}, last_out);
            if (sample_valid && !sample_stall)
                sb.note_group({sample_lane3, sample_lane2, sample_lane1, sample_lane0},
                              end_of_block);
        end
    end

    // End the run when neither channel moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((result_valid && !result_stall) || (sample_valid && !sample_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", idle_cycles);
                $display("tpdf_dither_24_to_16_test NOT OK");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial
    begin
        result_stall = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Offer one word, with an occasional gap first; return once taken
    task automatic send_word(input sample_t s0, input sample_t s1,
                             input sample_t s2, input sample_t s3, input logic eob);
        if (!calm && rush_left == 0 && $urandom_range(0, 5) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        if (rush_left > 0)
            rush_left--;
        sample_valid <= 1'b1;
        sample_lane0 <= s0;
        sample_lane1 <= s1;
        sample_lane2 <= s2;
        sample_lane3 <= s3;
        end_of_block <= eob;
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    // Mix of full-range, near-clamp and small samples
    function automatic sample_t rand_sample();
        int          v;
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 5))
            0:       v = 8388607 - int'($urandom_range(0, 600));
            1:       v = -8388608 + int'($urandom_range(0, 600));
            2:       v = int'($urandom_range(0, 2047)) - 1024;
            default: v = int'(r);
        endcase
        return v[23:0];
    endfunction

    // Hold the sender until every owed word has come out
    task automatic drain_outputs();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        sb            = new();
        calm          = 1'b0;
        long_hold_req = 1'b0;
        rush_left     = 0;
        idle_cycles   = 0;
        rst_n         = 1'b0;
        sample_valid  = 1'b0;
        sample_lane0  = '0;
        sample_lane1  = '0;
        sample_lane2  = '0;
        sample_lane3  = '0;
        end_of_block  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full scale both ways, zero, minus one, bit patterns
        send_word(FULL_POS, FULL_POS, FULL_POS, FULL_POS, 1'b0);
        send_word(FULL_NEG, FULL_NEG, FULL_NEG, FULL_NEG, 1'b1);
        send_word(FULL_POS, FULL_POS, FULL_POS, FULL_POS, 1'b0);
        send_word(FULL_NEG, FULL_NEG, FULL_NEG, FULL_NEG, 1'b0);
        send_word('0, '0, '0, '0, 1'b0);
        send_word(-24'sd1, -24'sd1, -24'sd1, -24'sd1, 1'b1);
        send_word(FULL_POS, FULL_NEG, '0, -24'sd1, 1'b0);
        send_word(24'sh7FFF80, 24'sh7FFF7F, 24'sh7FFF00, 24'sh7FFEFF, 1'b0);
        send_word(24'sh800080, 24'sh80007F, 24'sh800100, 24'sh8000FF, 1'b1);
        send_word(24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555, 1'b0);
        send_word(24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 1'b1);
        send_word(24'sd128, -24'sd128, 24'sd255, -24'sd256, 1'b0);
        send_word(FULL_POS, FULL_POS, FULL_POS, FULL_POS, 1'b1);
        send_word(FULL_NEG, FULL_NEG, FULL_NEG, FULL_NEG, 1'b1);
        send_word(24'sh000001, 24'sh7FFFFE, 24'sh800001, 24'shFFFF00, 1'b0);

        // Random words; long receiver hold and a full drain along the way
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == HOLD_AT)
            begin
                long_hold_req = 1'b1;
                rush_left     = RUSH_WORDS;
            end
            if (n == PAUSE_AT)
                drain_outputs();
            calm = (n >= RANDOM_WORDS - CALM_WORDS);
            send_word(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                      $urandom_range(0, 15) == 0);
        end

        // Drop valid, wait for the last words, then allow for latency
        drain_outputs();
        repeat (4) @(posedge clk);

        $display("checked %0d words of four lanes, %0d lane clamps, %0d block ends",
                 sb.words_checked, sb.clamp_hits, sb.block_ends);
        $display("random stalls on both sides, one long output hold, one full drain");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tpdf_dither_24_to_16_test OK");
        else
            $display("tpdf_dither_24_to_16_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+design
design/tpd_pkg.sv
design/tpd_lane.sv
design/tpd_out_stage.sv
design/tpdf_dither_24_to_16.sv
bench/tpdf_dither_24_to_16_test.sv
